// ===== hdl/b64pd_pkg.sv =====
package b64pd_pkg;

  // Character codes the decoder tests for
  localparam logic [7:0] CH_EQ   = 8'h3D;  // '=' pad
  localparam logic [7:0] CH_PLUS = 8'h2B;  // '+' symbol 62
  localparam logic [7:0] CH_PCT  = 8'h25;  // '%' symbol 63
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_Z = 8'h5A;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;

  localparam logic [5:0] SYM_PLUS = 6'd62;
  localparam logic [5:0] SYM_PCT  = 6'd63;
  localparam logic [7:0] LC_BASE  = 8'd26;
  localparam logic [7:0] DIG_BASE = 8'd52;

  // Masks for the bits kept over after the second and third symbol
  localparam logic [5:0] CARRY_MASK4 = 6'h0F;
  localparam logic [5:0] CARRY_MASK2 = 6'h03;

  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    TK_SYM = 2'd0,
    TK_PAD = 2'd1,
    TK_BAD = 2'd2,
    TK_EOT = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [5:0] sym;
  } token_t;

endpackage

// ===== hdl/base64_percent_decoder_unit.sv =====
// Channel  Direction  tdata                          tuser
// in_      slave      [7:0] char_code                [0] cmd (1 = end of text)
// out_     master     [7:0] data_byte, [8] error     [0] is_status
//
// Takes one transfer per cycle on each side when not stalled; a character
// passes through a queue entry, then the output register, to the output.
// The queue-head decode update sets the rate: one token a cycle unless stalled.
// rst_n is synchronous and clears the queue, the decode state and out_tvalid.
// A stall on out_tready holds the output register; the token queue of
// QUEUE_DEPTH entries absorbs input until it fills, then in_tready drops.
module base64_percent_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] char_code
  input  logic                              in_tuser,   // [0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [b64pd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] error
  output logic                              out_tuser   // [0] is_status
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  b64pd_pkg::token_t push_token;
  b64pd_pkg::token_t head_token;

  // Classify characters as they arrive
  b64pd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_token   (push_token)
  );

  // Decouple intake from decoding
  b64pd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head_token (head_token)
  );

  // Run the group state and drive the result register
  b64pd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_token    (head_token),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/b64pd_front.sv =====
module b64pd_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [7:0]        in_tdata,
  input  logic              q_full,
  output logic              q_push,
  output b64pd_pkg::token_t q_token
);

  logic [7:0] ofs;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the character and map it to its 6-bit value
  always_comb begin
    ofs = 8'd0;
    q_token.kind = b64pd_pkg::TK_BAD;
    q_token.sym  = 6'd0;
    if (in_tuser) begin
      q_token.kind = b64pd_pkg::TK_EOT;
    end else if (in_tdata == b64pd_pkg::CH_EQ) begin
      q_token.kind = b64pd_pkg::TK_PAD;
    end else if (in_tdata >= b64pd_pkg::CH_UC_A && in_tdata <= b64pd_pkg::CH_UC_Z) begin
      ofs = in_tdata - b64pd_pkg::CH_UC_A;
      q_token.kind = b64pd_pkg::TK_SYM;
      q_token.sym  = ofs[5:0];
    end else if (in_tdata >= b64pd_pkg::CH_LC_A && in_tdata <= b64pd_pkg::CH_LC_Z) begin
      ofs = in_tdata - b64pd_pkg::CH_LC_A + b64pd_pkg::LC_BASE;
      q_token.kind = b64pd_pkg::TK_SYM;
      q_token.sym  = ofs[5:0];
    end else if (in_tdata >= b64pd_pkg::CH_D0 && in_tdata <= b64pd_pkg::CH_D9) begin
      ofs = in_tdata - b64pd_pkg::CH_D0 + b64pd_pkg::DIG_BASE;
      q_token.kind = b64pd_pkg::TK_SYM;
      q_token.sym  = ofs[5:0];
    end else if (in_tdata == b64pd_pkg::CH_PLUS) begin
      q_token.kind = b64pd_pkg::TK_SYM;
      q_token.sym  = b64pd_pkg::SYM_PLUS;
    end else if (in_tdata == b64pd_pkg::CH_PCT) begin
      q_token.kind = b64pd_pkg::TK_SYM;
      q_token.sym  = b64pd_pkg::SYM_PCT;
    end
  end

endmodule

// ===== hdl/b64pd_fifo.sv =====
module b64pd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64pd_pkg::token_t push_token,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output b64pd_pkg::token_t head_token
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  b64pd_pkg::token_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_token = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

// ===== hdl/b64pd_back.sv =====
module b64pd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  b64pd_pkg::token_t                  q_token,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tuser,
  output logic [b64pd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ONE   = 3'd1,
    PH_TWO   = 3'd2,
    PH_THREE = 3'd3,
    PH_PAD   = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic       failed_r, failed_nxt;
  logic       vld_r, vld_nxt;
  logic       user_r, user_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       err_r, err_nxt;
  logic       emit;
  logic       mid_group;

  // Advance whenever the output register is free or drains this cycle
  assign q_pop = !q_empty && (!vld_r || out_tready);

  assign out_tvalid = vld_r;
  assign out_tuser  = user_r;
  assign out_tdata  = {{(b64pd_pkg::OUT_TDATA_W - 9){1'b0}}, err_r, byte_r};

  assign mid_group = (phase_r == PH_ONE) || (phase_r == PH_TWO) || (phase_r == PH_THREE);

  always_comb begin
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    failed_nxt = failed_r;
    user_nxt   = user_r;
    byte_nxt   = byte_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    vld_nxt    = vld_r && !out_tready;
    if (q_pop) begin
      if (q_token.kind == b64pd_pkg::TK_EOT) begin
        emit       = 1'b1;
        user_nxt   = 1'b1;
        byte_nxt   = 8'd0;
        err_nxt    = failed_r || mid_group;
        phase_nxt  = PH_START;
        carry_nxt  = 6'd0;
        failed_nxt = 1'b0;
      end else if (failed_r) begin
        // drop characters until end of text
      end else if (phase_r != PH_START && phase_r != PH_ONE && phase_r != PH_TWO &&
                   phase_r != PH_THREE) begin
        if (q_token.kind != b64pd_pkg::TK_PAD) begin
          failed_nxt = 1'b1;
        end
      end else if (q_token.kind == b64pd_pkg::TK_PAD &&
                   (phase_r == PH_TWO || phase_r == PH_THREE)) begin
        phase_nxt = PH_PAD;
      end else if (q_token.kind != b64pd_pkg::TK_SYM) begin
        failed_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_START: begin
            carry_nxt = q_token.sym;
            phase_nxt = PH_ONE;
          end
          PH_ONE: begin
            emit      = 1'b1;
            byte_nxt  = {carry_r, q_token.sym[5:4]};
            carry_nxt = q_token.sym & b64pd_pkg::CARRY_MASK4;
            phase_nxt = PH_TWO;
          end
          PH_TWO: begin
            emit      = 1'b1;
            byte_nxt  = {carry_r[3:0], q_token.sym[5:2]};
            carry_nxt = q_token.sym & b64pd_pkg::CARRY_MASK2;
            phase_nxt = PH_THREE;
          end
          default: begin
            emit      = 1'b1;
            byte_nxt  = {carry_r[1:0], q_token.sym};
            carry_nxt = 6'd0;
            phase_nxt = PH_START;
          end
        endcase
        user_nxt = 1'b0;
        err_nxt  = 1'b0;
      end
    end
    if (emit) begin
      vld_nxt = 1'b1;
    end else begin
      user_nxt = user_r;
      byte_nxt = byte_r;
      err_nxt  = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      carry_r  <= 6'd0;
      failed_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      carry_r  <= carry_nxt;
      failed_r <= failed_nxt;
      vld_r    <= vld_nxt;
    end
    user_r <= user_nxt;
    byte_r <= byte_nxt;
    err_r  <= err_nxt;
  end

endmodule
